// ----- rtl/spoken_genre_name_matcher_defines.svh -----
// Assertion macros for the spoken genre name matcher.
// Included by the top level; depends on nothing else.
`ifndef SPOKEN_GENRE_NAME_MATCHER_DEFINES_SVH
`define SPOKEN_GENRE_NAME_MATCHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SGNM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define SGNM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// ----- rtl/sgnm_pkg.sv -----
// Shared types, pattern constants and helper functions for the genre matcher.
// Used by sgnm_match_core and spoken_genre_name_matcher; depends on nothing.
package sgnm_pkg;

   localparam int WinLen          = 11;
   localparam int ShortMax        = 10;
   localparam int NumLong         = 3;
   localparam int NumShort        = 7;
   localparam int MaxCharsDefault = 127;

   typedef logic [7:0]                   byte_type;
   typedef logic [WinLen-1:0][7:0]       window_type;
   typedef logic [ShortMax-1:0][7:0]     short_pat_type;
   typedef logic [NumShort-1:0]          alive_type;
   typedef logic [3:0]                   len_type;

   typedef enum logic [1:0] {
      KIND_NONE      = 2'd0,
      KIND_CONTAINED = 2'd1,
      KIND_EXACT     = 2'd2
   } match_kind_type;

   typedef struct packed {
      logic           is_spoken;
      match_kind_type kind;
   } verdict_type;

   // Patterns are right-aligned: character i of a pattern of length n sits at
   // element n-1-i, which is where the window holds it once the match ends.
   localparam window_type LONG_PAT [NumLong] = '{
      window_type'("audiobook"),
      window_type'("audio book"),
      window_type'("spoken word")
   };
   localparam len_type LONG_LEN [NumLong] = '{4'd9, 4'd10, 4'd11};

   localparam short_pat_type SHORT_PAT [NumShort] = '{
      short_pat_type'("book"),
      short_pat_type'("books"),
      short_pat_type'("spoken"),
      short_pat_type'("speech"),
      short_pat_type'("non-music"),
      short_pat_type'("nonmusic"),
      short_pat_type'("podcast")
   };
   localparam len_type SHORT_LEN [NumShort] = '{4'd4, 4'd5, 4'd6, 4'd6, 4'd9, 4'd8, 4'd7};

   localparam byte_type ByteNul    = 8'h00;
   localparam byte_type UpperFirst = 8'h41;
   localparam byte_type UpperLast  = 8'h5A;
   localparam byte_type CaseOffset = 8'h20;

   function automatic byte_type fold_byte(byte_type b);
      byte_type r;
      r = b;
      if (b >= UpperFirst && b <= UpperLast) begin
         r = b + CaseOffset;
      end
      return r;
   endfunction

   function automatic logic long_hit(window_type win, int p);
      logic hit;
      hit = 1'b1;
      for (int j = 0; j < WinLen; j++) begin
         if (j < int'(LONG_LEN[p]) && win[j] != LONG_PAT[p][j]) begin
            hit = 1'b0;
         end
      end
      return hit;
   endfunction

endpackage

// ----- rtl/sgnm_match_core.sv -----
// Per-string match state: byte window, contained flag, exact alive bits, count.
// Updates once per stepped item and presents the verdict for the terminator.
// Depends on sgnm_pkg.
module sgnm_match_core #(
   parameter int MaxChars = sgnm_pkg::MaxCharsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  sgnm_pkg::byte_type   text_byte,
   output sgnm_pkg::verdict_type verdict
);

   localparam int CountWidth = $clog2(MaxChars + 1);

   sgnm_pkg::window_type  window_ff,    window_in;
   logic                  contained_ff, contained_in;
   sgnm_pkg::alive_type   alive_ff,     alive_in;
   logic [CountWidth-1:0] count_ff,     count_in;

   sgnm_pkg::byte_type    folded;
   sgnm_pkg::window_type  shifted;
   logic                  any_long;
   logic                  any_exact;
   logic [3:0]            pos;
   logic [3:0]            idx;

   always_comb begin
      folded  = sgnm_pkg::fold_byte(text_byte);
      shifted = {window_ff[sgnm_pkg::WinLen-2:0], folded};
      pos     = count_ff[3:0];

      any_long = 1'b0;
      for (int p = 0; p < sgnm_pkg::NumLong; p++) begin
         any_long = any_long | sgnm_pkg::long_hit(shifted, p);
      end

      window_in    = window_ff;
      contained_in = contained_ff;
      alive_in     = alive_ff;
      count_in     = count_ff;
      idx          = 4'd0;

      if (step) begin
         if (text_byte == sgnm_pkg::ByteNul) begin
            window_in    = '0;
            contained_in = 1'b0;
            alive_in     = '1;
            count_in     = '0;
         end else if (count_ff < CountWidth'(MaxChars)) begin
            window_in    = shifted;
            contained_in = contained_ff | any_long;
            for (int k = 0; k < sgnm_pkg::NumShort; k++) begin
               if (count_ff < CountWidth'(sgnm_pkg::SHORT_LEN[k])) begin
                  idx = sgnm_pkg::SHORT_LEN[k] - 4'd1 - pos;
                  if (sgnm_pkg::SHORT_PAT[k][idx] != folded) begin
                     alive_in[k] = 1'b0;
                  end
               end else begin
                  alive_in[k] = 1'b0;
               end
            end
            count_in = count_ff + CountWidth'(1);
         end
      end
   end

   always_comb begin
      any_exact = 1'b0;
      for (int k = 0; k < sgnm_pkg::NumShort; k++) begin
         if (alive_ff[k] && count_ff == CountWidth'(sgnm_pkg::SHORT_LEN[k])) begin
            any_exact = 1'b1;
         end
      end
      verdict.kind = sgnm_pkg::KIND_NONE;
      if (count_ff != '0) begin
         if (contained_ff) begin
            verdict.kind = sgnm_pkg::KIND_CONTAINED;
         end else if (any_exact) begin
            verdict.kind = sgnm_pkg::KIND_EXACT;
         end
      end
      verdict.is_spoken = (verdict.kind != sgnm_pkg::KIND_NONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= '0;
         contained_ff <= 1'b0;
         alive_ff     <= '1;
         count_ff     <= '0;
      end else begin
         window_ff    <= window_in;
         contained_ff <= contained_in;
         alive_ff     <= alive_in;
         count_ff     <= count_in;
      end
   end

endmodule

// ----- rtl/spoken_genre_name_matcher.sv -----
// Spoken genre name matcher: one string byte per item, one verdict per string.
// Flow: a byte accepted into the input register is stepped from there into the match state;
// a terminator also loads its verdict into the result register, and rsp_valid rises with that load.
// Throughput: one byte per cycle; only a terminator waits on a full result register.
// Reset empties the input and result registers and clears the per-string match state.
// Depends on sgnm_pkg, sgnm_match_core and spoken_genre_name_matcher_defines.svh.
`include "spoken_genre_name_matcher_defines.svh"

module spoken_genre_name_matcher #(
   parameter int MaxChars = sgnm_pkg::MaxCharsDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_text_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_is_spoken,
   output logic [1:0] rsp_match_kind
);

   logic                  in_valid_ff, in_valid_in;
   sgnm_pkg::byte_type    in_byte_ff;
   logic                  out_valid_ff, out_valid_in;
   sgnm_pkg::verdict_type out_verdict_ff;
   sgnm_pkg::verdict_type verdict;
   logic                  is_term;
   logic                  out_free;
   logic                  advance;
   logic                  req_take;

   assign is_term  = (in_byte_ff == sgnm_pkg::ByteNul);
   assign out_free = !out_valid_ff || !rsp_stall;
   assign advance  = in_valid_ff && (!is_term || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   sgnm_match_core #(
      .MaxChars(MaxChars)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .text_byte (in_byte_ff),
      .verdict   (verdict)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance && is_term) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_text_byte;
      end
      if (advance && is_term) begin
         out_verdict_ff <= verdict;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_is_spoken  = out_verdict_ff.is_spoken;
   assign rsp_match_kind = 2'(out_verdict_ff.kind);

   `SGNM_ASSERT_NEXT(a_take_fills_input, clock, reset, req_take, in_valid_ff)
   `SGNM_ASSERT_NEXT(a_term_loads_result, clock, reset, advance && is_term, rsp_valid)
   `SGNM_ASSERT_NOW(a_spoken_matches_kind, clock, reset, rsp_valid,
      rsp_is_spoken == (rsp_match_kind != sgnm_pkg::KIND_NONE))

endmodule

// ----- bench/tb_spoken_genre_name_matcher.sv -----
// Testbench for spoken_genre_name_matcher: streams genre strings one byte per item and
// checks every verdict against a matcher model that is updated on each accepted byte.
// Depends on sgnm_pkg and the matcher RTL.
module tb_spoken_genre_name_matcher;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MaxChars   = sgnm_pkg::MaxCharsDefault;
   localparam int HoldCycles = 300;
   localparam int RandomBytes = 700;
   localparam logic [7:0] Terminator = 8'h00;

   typedef struct {
      logic                    spoken;
      sgnm_pkg::match_kind_type kind;
   } verdict_t;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_text_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_is_spoken;
   logic [1:0] rsp_match_kind;

   verdict_t   expected_verdicts[$];
   int         mismatch_count = 0;
   bit         sender_quiet = 1'b0;
   bit         receiver_quiet = 1'b0;
   int         hold_request = 0;

   // Matcher model state.
   logic [7:0] folded_window [11];
   logic       long_seen;
   logic [6:0] short_alive;
   logic [6:0] taken_count;

   string long_names [3] = '{"audiobook", "audio book", "spoken word"};
   string short_names [7] = '{"book", "books", "spoken", "speech", "non-music",
                              "nonmusic", "podcast"};

   spoken_genre_name_matcher DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_text_byte  (req_text_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_is_spoken  (rsp_is_spoken),
      .rsp_match_kind (rsp_match_kind)
   );

   always #1 clock = ~clock;

   task automatic clear_matcher_model();
      for (int i = 0; i < 11; i++) begin
         folded_window[i] = 8'h00;
      end
      long_seen   = 1'b0;
      short_alive = 7'h7F;
      taken_count = 7'd0;
   endtask

   task automatic track_genre_byte(input logic [7:0] b);
      logic [7:0] f;
      logic       hit;
      int         n;
      verdict_t   v;
      if (b == Terminator) begin
         v.kind = sgnm_pkg::KIND_NONE;
         if (taken_count != 0) begin
            if (long_seen) begin
               v.kind = sgnm_pkg::KIND_CONTAINED;
            end else begin
               for (int k = 0; k < 7; k++) begin
                  if (short_alive[k] && int'(taken_count) == short_names[k].len()) begin
                     v.kind = sgnm_pkg::KIND_EXACT;
                  end
               end
            end
         end
         v.spoken = (v.kind != sgnm_pkg::KIND_NONE);
         expected_verdicts.push_back(v);
         clear_matcher_model();
      end else if (int'(taken_count) < MaxChars) begin
         f = b;
         if (b >= 8'h41 && b <= 8'h5A) begin
            f = b + 8'h20;
         end
         for (int i = 10; i > 0; i--) begin
            folded_window[i] = folded_window[i-1];
         end
         folded_window[0] = f;
         for (int p = 0; p < 3; p++) begin
            n = long_names[p].len();
            hit = 1'b1;
            for (int i = 0; i < n; i++) begin
               if (folded_window[n-1-i] != 8'(long_names[p][i])) begin
                  hit = 1'b0;
               end
            end
            if (hit) begin
               long_seen = 1'b1;
            end
         end
         for (int k = 0; k < 7; k++) begin
            if (int'(taken_count) >= short_names[k].len() ||
                8'(short_names[k][taken_count]) != f) begin
               short_alive[k] = 1'b0;
            end
         end
         taken_count = taken_count + 7'd1;
      end
   endtask

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = sender_quiet ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_text_byte <= b;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      track_genre_byte(b);
      @(negedge clock);
   endtask

   task automatic send_name(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(8'(s[i]));
      end
      send_byte(Terminator);
   endtask

   task automatic wait_for_verdicts();
      req_valid <= 1'b0;
      while (expected_verdicts.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [7:0] mix_case(input logic [7:0] c);
      if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1) == 1) begin
         return c - 8'h20;
      end
      return c;
   endfunction

   task automatic test_exact_names();
      send_name("");
      send_name("book");
      send_name("BOOKS");
      send_name("Spoken");
      send_name("sPEECH");
      send_name("NON-MUSIC");
      send_name("NonMusic");
      send_name("podcast");
      send_name("boo");
      send_name("bookss");
      send_name("Podcasts");
      wait_for_verdicts();
   endtask

   task automatic test_contained_names();
      send_name("AudioBook");
      send_name("my audio book club");
      send_name("Spoken Word");
      send_name("spoken words");
      send_name("audio-book");
      send_name("xaudiobooK");
      wait_for_verdicts();
   endtask

   task automatic test_odd_bytes();
      logic [7:0] odd [10] = '{8'hFF, 8'h80, 8'h7F, 8'h01, 8'h40, 8'h5B, 8'h60, 8'h7B,
                               8'hE2, 8'hC2};
      foreach (odd[i]) begin
         send_byte(odd[i]);
      end
      send_byte(Terminator);
      send_byte(8'hC2);
      send_name("ook");
      send_byte(8'h42);
      send_byte(8'h6F);
      send_byte(8'h4F);
      send_byte(8'hEB);
      send_byte(Terminator);
      wait_for_verdicts();
   endtask

   task automatic test_overlong_names();
      int fill;
      for (int round = 0; round < 4; round++) begin
         fill = (round == 0) ? 118 : (round == 1) ? 119 : (round == 2) ? 130 : 116;
         for (int i = 0; i < fill; i++) begin
            send_byte(8'h78);
         end
         send_name("audiobook");
      end
      send_byte(8'h62);
      send_byte(8'h6F);
      send_byte(8'h6F);
      send_byte(8'h6B);
      for (int i = 0; i < 200; i++) begin
         send_byte(8'($urandom_range(1, 255)));
      end
      send_byte(Terminator);
      wait_for_verdicts();
   endtask

   task automatic test_backpressure();
      sender_quiet = 1'b1;
      hold_request = HoldCycles;
      for (int i = 0; i < 60; i++) begin
         send_name((i % 2 == 0) ? "Books" : "audio book");
      end
      sender_quiet = 1'b0;
      wait_for_verdicts();
   endtask

   task automatic test_random_names();
      logic [7:0] name[$];
      string      pat;
      int         sent;
      int         strings;
      int         mode;
      int         cut;
      sent = 0;
      strings = 0;
      while (sent < RandomBytes) begin
         if (strings % 40 == 0) begin
            sender_quiet   = ($urandom_range(0, 3) == 0);
            receiver_quiet = ($urandom_range(0, 3) == 0);
         end
         name.delete();
         mode = $urandom_range(0, 19);
         if (mode < 8) begin
            pat = short_names[$urandom_range(0, 6)];
            for (int i = 0; i < pat.len(); i++) begin
               name.push_back(mix_case(8'(pat[i])));
            end
         end else if (mode < 14 || (mode == 17 && $urandom_range(0, 3) != 0)) begin
            pat = long_names[$urandom_range(0, 2)];
            repeat ($urandom_range(0, 6)) name.push_back(8'($urandom_range(1, 255)));
            for (int i = 0; i < pat.len(); i++) begin
               name.push_back(mix_case(8'(pat[i])));
            end
            repeat ($urandom_range(0, 6)) name.push_back(8'($urandom_range(1, 255)));
         end else if (mode < 16) begin
            repeat ($urandom_range(0, 12)) name.push_back(8'($urandom_range(1, 255)));
         end else if (mode == 16) begin
            pat = short_names[$urandom_range(0, 6)];
            cut = $urandom_range(1, pat.len());
            for (int i = 0; i < cut; i++) begin
               name.push_back(mix_case(8'(pat[i])));
            end
            if ($urandom_range(0, 1) == 1) begin
               name.push_back(8'($urandom_range(8'h61, 8'h7A)));
            end
         end else begin
            repeat ($urandom_range(100, 135)) name.push_back(8'($urandom_range(8'h61, 8'h7A)));
            pat = long_names[$urandom_range(0, 2)];
            for (int i = 0; i < pat.len(); i++) begin
               name.push_back(mix_case(8'(pat[i])));
            end
         end
         if (mode < 14 && name.size() > 0 && $urandom_range(0, 3) == 0) begin
            name[$urandom_range(0, name.size() - 1)] = 8'($urandom_range(1, 255));
         end
         foreach (name[i]) begin
            send_byte(name[i]);
         end
         send_byte(Terminator);
         sent += name.size() + 1;
         strings++;
      end
      sender_quiet   = 1'b0;
      receiver_quiet = 1'b0;
      wait_for_verdicts();
   endtask

   initial begin : verdict_checker
      int       gap;
      verdict_t want;
      rsp_stall <= 1'b0;
      @(negedge clock);
      while (reset) begin
         @(negedge clock);
      end
      forever begin
         if (hold_request > 0) begin
            gap = hold_request;
            hold_request = 0;
         end else begin
            gap = receiver_quiet ? 0 : $urandom_range(0, 5);
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) begin
            @(posedge clock);
         end
         if (expected_verdicts.size() == 0) begin
            $error("unexpected verdict: is_spoken %0d match_kind %0d",
                   rsp_is_spoken, rsp_match_kind);
            mismatch_count++;
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_is_spoken !== want.spoken) begin
               $error("is_spoken: expected %0d, actual %0d", want.spoken, rsp_is_spoken);
               mismatch_count++;
            end
            if (rsp_match_kind !== want.kind) begin
               $error("match_kind: expected %0d, actual %0d", want.kind, rsp_match_kind);
               mismatch_count++;
            end
         end
         @(negedge clock);
      end
   end

   initial begin
      #1ms;
      $display("spoken_genre_name_matcher test failed");
      $finish;
   end

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_text_byte <= 8'h00;
      clear_matcher_model();
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      test_exact_names();
      test_contained_names();
      test_odd_bytes();
      test_overlong_names();
      test_backpressure();
      test_random_names();
      if (expected_verdicts.size() != 0) begin
         $error("%0d verdicts never arrived", expected_verdicts.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("spoken_genre_name_matcher test passed");
      end else begin
         $display("spoken_genre_name_matcher test failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/sgnm_pkg.sv
rtl/sgnm_match_core.sv
rtl/spoken_genre_name_matcher.sv
bench/tb_spoken_genre_name_matcher.sv
